@@ hw/rtl/first_fit_heap_allocator_defines.svh @@
// Assertion macros for the first-fit heap allocator checker
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define FFHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/ffha_pkg.sv @@
// Shared types and constants of the first-fit heap allocator
`timescale 1ns / 1ps
package ffha_pkg;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_REALLOC = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SET_FREE,
    CELL_CLR_FREE,
    CELL_WRITE,
    CELL_ABSORB,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_EXEC,
    ST_MERGE_R,
    ST_MERGE_L,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] payload;
    logic        free;
  } cell_t;

  localparam logic [2:0] REG_HEAP_LIMIT = 3'd0;
  localparam logic [16:0] HEAP_LIMIT_RST = 17'd65536;

endpackage

@@ hw/rtl/ffha_if.sv @@
// Request and response channel interfaces
`timescale 1ns / 1ps
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] size;
  logic [15:0] address;
  logic        address_is_null;
  modport source (output valid, action, size, address, address_is_null, input ready);
  modport sink (input valid, action, size, address, address_is_null, output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_address;
  logic        result_is_null;
  logic [15:0] copy_bytes;
  logic        bad_address;
  modport source (output valid, result_address, result_is_null, copy_bytes, bad_address,
                  input ready);
  modport sink (input valid, result_address, result_is_null, copy_bytes, bad_address,
                output ready);
endinterface

@@ hw/rtl/ffha_cell.sv @@
// One table entry: holds a block, matches requests, takes data from its right neighbor
`timescale 1ns / 1ps
module ffha_cell #(
  parameter int HEADER_BYTES = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffha_pkg::cell_op_e  op_i,
  input  logic                valid_i,
  input  logic [15:0]         wr_start_i,
  input  logic [15:0]         wr_payload_i,
  input  logic [15:0]         req_size_i,
  input  logic [15:0]         req_address_i,
  input  ffha_pkg::cell_t     right_i,
  output ffha_pkg::cell_t     cell_o,
  output logic                hit_used_o,
  output logic                hit_fit_o
);

  localparam logic [17:0] HDR = 18'(HEADER_BYTES);

  logic [15:0] start_q, start_d, payload_q, payload_d;
  logic        free_q, free_d;
  logic [17:0] sum;

  assign sum = 18'(payload_q) + HDR + 18'(right_i.payload);

  always_comb begin
    start_d   = start_q;
    payload_d = payload_q;
    free_d    = free_q;
    case (op_i)
      ffha_pkg::CELL_HOLD: ;
      ffha_pkg::CELL_SET_FREE: free_d = 1'b1;
      ffha_pkg::CELL_CLR_FREE: free_d = 1'b0;
      ffha_pkg::CELL_WRITE: begin
        start_d   = wr_start_i;
        payload_d = wr_payload_i;
        free_d    = 1'b0;
      end
      ffha_pkg::CELL_ABSORB: payload_d = (sum > 18'd65535) ? 16'hFFFF : sum[15:0];
      ffha_pkg::CELL_SHIFT: begin
        start_d   = right_i.start;
        payload_d = right_i.payload;
        free_d    = right_i.free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    start_q   <= start_d;
    payload_q <= payload_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= 1'b0;
    end else begin
      free_q <= free_d;
    end
  end

  assign cell_o     = '{start: start_q, payload: payload_q, free: free_q};
  assign hit_used_o = valid_i && !free_q &&
                      ((17'(start_q) + 17'(HEADER_BYTES)) == 17'(req_address_i));
  assign hit_fit_o  = valid_i && free_q && (payload_q >= req_size_i);

endmodule

@@ hw/rtl/first_fit_heap_allocator.sv @@
// Top level of the first-fit heap allocator
// Keeps up to MAX_BLOCKS heap blocks in a row of cells, ordered by address. After a
// request is accepted, FIND matches it in all cells, EXEC grants or releases, and DONE
// registers the result for output. A transaction that releases a block also passes
// through MERGE_R and MERGE_L before DONE. This covers a free, a reallocate to zero
// size and a moving reallocate. Those states merge the right and then the left
// neighbor, and are passed whether or not that neighbor is free. A new request is
// taken only in IDLE, after the result of the last one is registered, and so comes
// later while a waiting result is not taken. heap_limit may be written over APB at
// address 0 while no transaction is in flight.
`timescale 1ns / 1ps
module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffha_req_if.sink    req_i,
  ffha_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int CAP_I = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
  localparam logic [16:0] CAP = 17'(CAP_I);
  localparam logic [17:0] HDR = 18'(HEADER_BYTES);
  localparam logic [CW-1:0] FULL = CW'(MAX_BLOCKS);

  ffha_pkg::state_e state_q, state_d;
  logic [16:0] limit_q;
  logic [1:0]  act_q;
  logic [15:0] size_q, addr_q;
  logic        null_q;

  logic [CW-1:0] count_q, count_d;
  logic [16:0]   top_q, top_d;

  ffha_pkg::cell_t    cell_row [MAX_BLOCKS];
  ffha_pkg::cell_op_e op [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] used_vec, fit_vec, fit_first;

  logic          used_hit_q, fit_hit_q;
  logic [IW-1:0] used_idx_q, fit_idx_q, used_idx_c, fit_idx_c;
  logic [IW-1:0] m_q, m_d;

  logic [15:0] res_q, res_d, copy_q, copy_d;
  logic        ok_q, ok_d, bad_q, bad_d;
  logic        set_en, clr_en, wr_en, merge_q, merge_d;

  logic        rsp_valid_q;
  logic [15:0] rsp_addr_q, rsp_copy_q;
  logic        rsp_null_q, rsp_bad_q;

  logic [16:0] bound;
  logic [17:0] need;
  logic        mr_en, ml_en;
  logic [IW-1:0] m_up, m_dn;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ffha_pkg::REG_HEAP_LIMIT) ? {15'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ffha_pkg::HEAP_LIMIT_RST;
    end else if (psel && penable && pwrite && paddr == ffha_pkg::REG_HEAP_LIMIT) begin
      limit_q <= pwdata[16:0];
    end
  end

  assign bound = (limit_q < CAP) ? limit_q : CAP;
  assign need  = 18'(top_q) + HDR + 18'(size_q);

  // Cell row
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    ffha_pkg::cell_t right;
    if (i == MAX_BLOCKS - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = cell_row[i+1];
    end
    ffha_cell #(.HEADER_BYTES(HEADER_BYTES)) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (op[i]),
      .valid_i       (CW'(i) < count_q),
      .wr_start_i    (top_q[15:0]),
      .wr_payload_i  (size_q),
      .req_size_i    (size_q),
      .req_address_i (addr_q),
      .right_i       (right),
      .cell_o        (cell_row[i]),
      .hit_used_o    (used_vec[i]),
      .hit_fit_o     (fit_vec[i])
    );
  end

  assign fit_first = fit_vec & (~fit_vec + 1'b1);

  always_comb begin
    used_idx_c = '0;
    fit_idx_c  = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (used_vec[i]) used_idx_c = used_idx_c | IW'(i);
      if (fit_first[i]) fit_idx_c = fit_idx_c | IW'(i);
    end
  end

  assign m_up  = IW'(m_q + 1'b1);
  assign m_dn  = IW'(m_q - 1'b1);
  assign mr_en = ((CW'(m_q) + 1'b1) < count_q) && cell_row[m_up].free;
  assign ml_en = (m_q != '0) && cell_row[m_dn].free;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ffha_pkg::ST_IDLE:    if (req_i.valid) state_d = ffha_pkg::ST_FIND;
      ffha_pkg::ST_FIND:    state_d = ffha_pkg::ST_EXEC;
      ffha_pkg::ST_EXEC:    state_d = merge_d ? ffha_pkg::ST_MERGE_R : ffha_pkg::ST_DONE;
      ffha_pkg::ST_MERGE_R: state_d = ffha_pkg::ST_MERGE_L;
      ffha_pkg::ST_MERGE_L: state_d = ffha_pkg::ST_DONE;
      ffha_pkg::ST_DONE:    if (!rsp_valid_q || rsp_o.ready) state_d = ffha_pkg::ST_IDLE;
      default:              state_d = ffha_pkg::ST_IDLE;
    endcase
  end

  // Grant and release decisions
  always_comb begin
    res_d   = res_q;
    copy_d  = copy_q;
    ok_d    = ok_q;
    bad_d   = bad_q;
    merge_d = merge_q;
    m_d     = m_q;
    set_en  = 1'b0;
    clr_en  = 1'b0;
    wr_en   = 1'b0;
    if (state_q == ffha_pkg::ST_EXEC) begin
      res_d   = '0;
      copy_d  = '0;
      ok_d    = 1'b0;
      bad_d   = 1'b0;
      merge_d = 1'b0;
      m_d     = used_idx_q;
      if (act_q == ffha_pkg::ACT_ALLOC || (act_q == ffha_pkg::ACT_REALLOC && null_q) ||
          (act_q == ffha_pkg::ACT_REALLOC && used_hit_q && size_q != '0 &&
           cell_row[used_idx_q].payload < size_q)) begin
        if (size_q == '0) begin
          ok_d = 1'b0;
        end else if (fit_hit_q) begin
          ok_d   = 1'b1;
          clr_en = 1'b1;
          res_d  = 16'(17'(cell_row[fit_idx_q].start) + 17'(HEADER_BYTES));
        end else if (count_q != FULL && need <= 18'(bound)) begin
          ok_d  = 1'b1;
          wr_en = 1'b1;
          res_d = 16'(18'(top_q) + HDR);
        end
        if (act_q == ffha_pkg::ACT_REALLOC && !null_q && ok_d) begin
          copy_d  = cell_row[used_idx_q].payload;
          set_en  = 1'b1;
          merge_d = 1'b1;
        end
      end else if (act_q == ffha_pkg::ACT_FREE || act_q == ffha_pkg::ACT_REALLOC) begin
        if (!null_q) begin
          if (!used_hit_q) begin
            bad_d = 1'b1;
          end else if (act_q == ffha_pkg::ACT_FREE || size_q == '0) begin
            set_en  = 1'b1;
            merge_d = 1'b1;
          end else begin
            ok_d  = 1'b1;
            res_d = addr_q;
          end
        end
      end
    end
  end

  // Cell commands
  always_comb begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      op[i] = ffha_pkg::CELL_HOLD;
      case (state_q)
        ffha_pkg::ST_EXEC: begin
          if (set_en && IW'(i) == used_idx_q) op[i] = ffha_pkg::CELL_SET_FREE;
          if (clr_en && IW'(i) == fit_idx_q) op[i] = ffha_pkg::CELL_CLR_FREE;
          if (wr_en && CW'(i) == count_q) op[i] = ffha_pkg::CELL_WRITE;
        end
        ffha_pkg::ST_MERGE_R: begin
          if (merge_q && mr_en) begin
            if (IW'(i) == m_q) op[i] = ffha_pkg::CELL_ABSORB;
            else if (IW'(i) > m_q) op[i] = ffha_pkg::CELL_SHIFT;
          end
        end
        ffha_pkg::ST_MERGE_L: begin
          if (merge_q && ml_en) begin
            if (IW'(i) == m_dn) op[i] = ffha_pkg::CELL_ABSORB;
            else if (IW'(i) >= m_q) op[i] = ffha_pkg::CELL_SHIFT;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    top_d   = top_q;
    if (wr_en) begin
      count_d = count_q + 1'b1;
      top_d   = 17'(need);
    end
    if ((state_q == ffha_pkg::ST_MERGE_R && merge_q && mr_en) ||
        (state_q == ffha_pkg::ST_MERGE_L && merge_q && ml_en)) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffha_pkg::ST_IDLE;
      count_q     <= '0;
      top_q       <= '0;
      merge_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      top_q   <= top_d;
      merge_q <= merge_d;
      if (state_q == ffha_pkg::ST_DONE && (!rsp_valid_q || rsp_o.ready)) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ffha_pkg::ST_IDLE && req_i.valid) begin
      act_q  <= req_i.action;
      size_q <= req_i.size;
      addr_q <= req_i.address;
      null_q <= req_i.address_is_null;
    end
    if (state_q == ffha_pkg::ST_FIND) begin
      used_hit_q <= |used_vec;
      fit_hit_q  <= |fit_vec;
      used_idx_q <= used_idx_c;
      fit_idx_q  <= fit_idx_c;
    end
    res_q  <= res_d;
    copy_q <= copy_d;
    ok_q   <= ok_d;
    bad_q  <= bad_d;
    m_q    <= m_d;
    if (state_q == ffha_pkg::ST_DONE && (!rsp_valid_q || rsp_o.ready)) begin
      rsp_addr_q <= ok_q ? res_q : 16'd0;
      rsp_null_q <= !ok_q;
      rsp_copy_q <= ok_q ? copy_q : 16'd0;
      rsp_bad_q  <= bad_q;
    end
  end

  assign req_i.ready          = (state_q == ffha_pkg::ST_IDLE);
  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.result_address = rsp_addr_q;
  assign rsp_o.result_is_null = rsp_null_q;
  assign rsp_o.copy_bytes     = rsp_copy_q;
  assign rsp_o.bad_address    = rsp_bad_q;

endmodule

@@ hw/rtl/ffha_checker.sv @@
// Port-level checker for the first-fit heap allocator and its bind
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_defines.svh"
module ffha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [15:0] result_address_i,
  input logic        result_is_null_i,
  input logic [15:0] copy_bytes_i,
  input logic        bad_address_i
);

  `FFHA_ASSERT_IMPL(a_bad_null, clk_i, rst_ni, rsp_valid_i && bad_address_i, result_is_null_i)
  `FFHA_ASSERT_IMPL(a_null_zero, clk_i, rst_ni, rsp_valid_i && result_is_null_i, result_address_i == 16'd0 && copy_bytes_i == 16'd0)
  `FFHA_ASSERT_IMPL(a_copy_ok, clk_i, rst_ni, rsp_valid_i && copy_bytes_i != 16'd0, !result_is_null_i && !bad_address_i)
  `FFHA_ASSERT_NEXT(a_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(result_address_i))

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .result_address_i (rsp_o.result_address),
  .result_is_null_i (rsp_o.result_is_null),
  .copy_bytes_i     (rsp_o.copy_bytes),
  .bad_address_i    (rsp_o.bad_address)
);

@@ tb/testbench.sv @@
// Self-checking regression of the first-fit heap allocator with a built-in heap table predictor
`timescale 1ns / 1ps
module testbench;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 24;

  typedef struct {
    logic [15:0] result_address;
    logic        result_is_null;
    logic [15:0] copy_bytes;
    logic        bad_address;
  } grant_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ffha_req_if req ();
  ffha_rsp_if rsp ();

  first_fit_heap_allocator #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // predicted heap table
  int unsigned heap_start [MAX_BLOCKS];
  int unsigned heap_payload [MAX_BLOCKS];
  bit          heap_free [MAX_BLOCKS];
  int unsigned heap_blocks;
  int unsigned heap_top;
  int unsigned heap_limit;

  grant_t pending_grants[$];
  int     error_count;
  bit     calm;
  bit     hold_request;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("first_fit_heap_allocator regression: fail");
    $finish;
  end

  function automatic int unsigned grow_bound();
    int unsigned b;
    b = heap_limit;
    if (HEAP_BYTES < b) b = HEAP_BYTES;
    if (65536 < b) b = 65536;
    return b;
  endfunction

  function automatic bit try_alloc(int unsigned sz, output int unsigned addr);
    addr = 0;
    if (sz == 0) return 1'b0;
    for (int unsigned i = 0; i < heap_blocks; i++) begin
      if (heap_free[i] && heap_payload[i] >= sz) begin
        heap_free[i] = 1'b0;
        addr = heap_start[i] + HEADER_BYTES;
        return 1'b1;
      end
    end
    if (heap_blocks >= MAX_BLOCKS) return 1'b0;
    if (heap_top + HEADER_BYTES + sz > grow_bound()) return 1'b0;
    heap_start[heap_blocks] = heap_top;
    heap_payload[heap_blocks] = sz;
    heap_free[heap_blocks] = 1'b0;
    heap_blocks++;
    addr = heap_top + HEADER_BYTES;
    heap_top += HEADER_BYTES + sz;
    return 1'b1;
  endfunction

  function automatic int find_used(int unsigned addr);
    for (int unsigned i = 0; i < heap_blocks; i++)
      if (!heap_free[i] && heap_start[i] + HEADER_BYTES == addr) return int'(i);
    return -1;
  endfunction

  function automatic void release_block(int idx);
    int unsigned i;
    int unsigned s;
    heap_free[idx] = 1'b1;
    i = 0;
    while (i + 1 < heap_blocks) begin
      if (heap_free[i] && heap_free[i+1]) begin
        s = heap_payload[i] + HEADER_BYTES + heap_payload[i+1];
        heap_payload[i] = (s > 65535) ? 65535 : s;
        for (int unsigned j = i + 1; j + 1 < heap_blocks; j++) begin
          heap_start[j] = heap_start[j+1];
          heap_payload[j] = heap_payload[j+1];
          heap_free[j] = heap_free[j+1];
        end
        heap_blocks--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic grant_t predict_grant(ffha_pkg::action_e act, int unsigned sz,
                                           int unsigned addr, bit is_null);
    grant_t g;
    int unsigned res;
    int unsigned old;
    int idx;
    bit ok;
    res = 0;
    ok = 1'b0;
    g.copy_bytes = '0;
    g.bad_address = 1'b0;
    case (act)
      ffha_pkg::ACT_ALLOC: begin
        ok = try_alloc(sz, res);
      end
      ffha_pkg::ACT_FREE: begin
        if (!is_null) begin
          idx = find_used(addr);
          if (idx < 0) g.bad_address = 1'b1;
          else release_block(idx);
        end
      end
      ffha_pkg::ACT_REALLOC: begin
        if (is_null) begin
          ok = try_alloc(sz, res);
        end else begin
          idx = find_used(addr);
          if (idx < 0) begin
            g.bad_address = 1'b1;
          end else if (sz == 0) begin
            release_block(idx);
          end else if (heap_payload[idx] >= sz) begin
            ok = 1'b1;
            res = addr;
          end else begin
            old = heap_payload[idx];
            ok = try_alloc(sz, res);
            if (ok) begin
              g.copy_bytes = (old < sz) ? old : sz;
              release_block(idx);
            end
          end
        end
      end
      default: ;
    endcase
    if (!ok) begin
      res = 0;
      g.copy_bytes = '0;
    end
    g.result_address = res[15:0];
    g.result_is_null = !ok;
    return g;
  endfunction

  task automatic send_request(ffha_pkg::action_e act, logic [15:0] sz, logic [15:0] addr,
                              bit is_null);
    grant_t g;
    if (!calm && $urandom_range(99) < 17) begin
      req.valid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    req.valid = 1'b1;
    req.action = act;
    req.size = sz;
    req.address = addr;
    req.address_is_null = is_null;
    do @(posedge clk_i); while (!req.ready);
    g = predict_grant(act, sz, addr, is_null);
    pending_grants.push_back(g);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req.valid = 1'b0;
    while (pending_grants.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_heap_limit(logic [31:0] value);
    wait_drained();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = ffha_pkg::REG_HEAP_LIMIT;
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    heap_limit = value & 32'h1FFFF;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic [15:0] live_address();
    int unsigned used[$];
    for (int unsigned i = 0; i < heap_blocks; i++)
      if (!heap_free[i]) used.push_back(i);
    if (used.size() == 0) return 16'($urandom);
    return 16'(heap_start[used[$urandom_range(used.size() - 1)]] + HEADER_BYTES);
  endfunction

  function automatic logic [15:0] random_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 75) return 16'($urandom_range(64, 1));
    if (r < 95) return 16'($urandom_range(1024, 65));
    return 16'($urandom);
  endfunction

  task automatic send_random_request();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) send_request(ffha_pkg::ACT_ALLOC, random_size(), 16'($urandom), 1'b0);
    else if (r < 65) send_request(ffha_pkg::ACT_FREE, 16'($urandom), live_address(), 1'b0);
    else if (r < 85) send_request(ffha_pkg::ACT_REALLOC, random_size(), live_address(), 1'b0);
    else if (r < 90) send_request(ffha_pkg::ACT_REALLOC, random_size(), 16'($urandom), 1'b1);
    else if (r < 94)
      send_request(ffha_pkg::action_e'($urandom_range(2, 1)), random_size(), 16'($urandom),
                   1'b0);
    else if (r < 97) send_request(ffha_pkg::ACT_FREE, 16'($urandom), 16'($urandom), 1'b1);
    else send_request(ffha_pkg::ACT_NONE, 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic test_directed_ops();
    grant_t a;
    grant_t b;
    logic [15:0] pa;
    logic [15:0] pb;
    send_request(ffha_pkg::ACT_ALLOC, 16'd0, 16'd0, 1'b0);
    send_request(ffha_pkg::ACT_ALLOC, 16'd100, 16'd0, 1'b0);
    pa = pending_grants[$].result_address;
    send_request(ffha_pkg::ACT_ALLOC, 16'd50, 16'd0, 1'b0);
    pb = pending_grants[$].result_address;
    send_request(ffha_pkg::ACT_ALLOC, 16'd200, 16'hFFFF, 1'b0);
    send_request(ffha_pkg::ACT_FREE, 16'd0, 16'd0, 1'b1);
    send_request(ffha_pkg::ACT_NONE, 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(ffha_pkg::ACT_FREE, 16'd0, pa + 16'd1, 1'b0);
    send_request(ffha_pkg::ACT_REALLOC, 16'd40, pb, 1'b0);
    send_request(ffha_pkg::ACT_REALLOC, 16'd300, pb, 1'b0);
    send_request(ffha_pkg::ACT_FREE, 16'd0, pa, 1'b0);
    send_request(ffha_pkg::ACT_FREE, 16'd0, pa, 1'b0);
    send_request(ffha_pkg::ACT_REALLOC, 16'd10, 16'd0, 1'b1);
    send_request(ffha_pkg::ACT_REALLOC, 16'd0, live_address(), 1'b0);
    send_request(ffha_pkg::ACT_REALLOC, 16'hFFFF, live_address(), 1'b0);
    send_request(ffha_pkg::ACT_ALLOC, 16'hFFFF, 16'd0, 1'b0);
    send_request(ffha_pkg::ACT_REALLOC, 16'd5, 16'hFFFF, 1'b0);
  endtask

  task automatic test_table_full();
    write_heap_limit(32'h1FFFF);
    repeat (MAX_BLOCKS + 4) send_request(ffha_pkg::ACT_ALLOC, 16'd1, 16'd0, 1'b0);
    for (int i = 0; i < MAX_BLOCKS; i++)
      send_request(ffha_pkg::ACT_FREE, 16'd0, live_address(), 1'b0);
  endtask

  task automatic test_growth_limit();
    write_heap_limit(32'd0);
    repeat (6) send_request(ffha_pkg::ACT_ALLOC, 16'($urandom_range(90, 1)), 16'd0, 1'b0);
    write_heap_limit(heap_top + 200);
    repeat (8) send_request(ffha_pkg::ACT_ALLOC, 16'($urandom_range(120, 20)), 16'd0, 1'b0);
    write_heap_limit(32'd65536);
  endtask

  task automatic test_back_pressure();
    hold_request = 1'b1;
    repeat (12) send_random_request();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [31:0] limits[4];
    limits = '{32'h1FFFF, 32'd65536, 32'd0, 32'($urandom_range(65536, 2048))};
    foreach (limits[p]) begin
      write_heap_limit(limits[p]);
      calm = (p == 1);
      repeat (440) send_random_request();
    end
    calm = 1'b0;
  endtask

  initial begin
    rsp.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp.ready = 1'b0;
        repeat (300) @(negedge clk_i);
      end
      rsp.ready = calm || ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk_i) begin
    grant_t g;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_grants.size() == 0) begin
        $error("result_address: unexpected transaction, actual %0d", rsp.result_address);
        error_count++;
      end else begin
        g = pending_grants.pop_front();
        if (rsp.result_address !== g.result_address) begin
          $error("result_address: expected %0d, actual %0d", g.result_address,
                 rsp.result_address);
          error_count++;
        end
        if (rsp.result_is_null !== g.result_is_null) begin
          $error("result_is_null: expected %0d, actual %0d", g.result_is_null,
                 rsp.result_is_null);
          error_count++;
        end
        if (rsp.copy_bytes !== g.copy_bytes) begin
          $error("copy_bytes: expected %0d, actual %0d", g.copy_bytes, rsp.copy_bytes);
          error_count++;
        end
        if (rsp.bad_address !== g.bad_address) begin
          $error("bad_address: expected %0d, actual %0d", g.bad_address, rsp.bad_address);
          error_count++;
        end
      end
    end
  end

  initial begin
    int unsigned waited;
    error_count = 0;
    calm = 1'b0;
    hold_request = 1'b0;
    heap_blocks = 0;
    heap_top = 0;
    heap_limit = ffha_pkg::HEAP_LIMIT_RST;
    foreach (heap_free[i]) begin
      heap_free[i] = 1'b0;
      heap_start[i] = 0;
      heap_payload[i] = 0;
    end
    req.valid = 1'b0;
    req.action = ffha_pkg::ACT_ALLOC;
    req.size = '0;
    req.address = '0;
    req.address_is_null = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_ops();
    test_table_full();
    test_growth_limit();
    test_back_pressure();
    test_random_traffic();

    req.valid = 1'b0;
    waited = 0;
    while (pending_grants.size() != 0 && waited < 100000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (20) @(negedge clk_i);
    if (error_count == 0 && pending_grants.size() == 0) begin
      $display("first_fit_heap_allocator regression: pass");
    end else begin
      $display("first_fit_heap_allocator regression: fail");
    end
    $finish;
  end

endmodule
